// ----- src/sfr_pkg.sv -----
// sfr_pkg: shared types, register codes and the crc-16 byte update
// for the sync/length/crc16 framer; no dependencies
package sfr_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned CRC_W     = 16;
	localparam int unsigned CFG_IDX_W = 8;

	localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
	localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_LENGTH = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST     = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND    = 8'd2;

	// reset values of the registers
	localparam logic [BYTE_W-1:0] RST_PAYLOAD_LENGTH = 8'd64;
	localparam logic [BYTE_W-1:0] RST_SYNC_FIRST     = 8'hAA;
	localparam logic [BYTE_W-1:0] RST_SYNC_SECOND    = 8'h55;

	// position of a byte within the run caused by one request
	typedef enum logic [2:0] {
		SLOT_SYNC_A = 3'd0,
		SLOT_SYNC_B = 3'd1,
		SLOT_LENGTH = 3'd2,
		SLOT_DATA   = 3'd3,
		SLOT_CRC_HI = 3'd4,
		SLOT_CRC_LO = 3'd5
	} slot_t;

	// everything needed to emit the run for one payload byte
	typedef struct packed {
		logic [BYTE_W-1:0] sync_a;
		logic [BYTE_W-1:0] sync_b;
		logic [BYTE_W-1:0] length;
		logic [BYTE_W-1:0] data;
		logic [CRC_W-1:0]  crc;
		logic              hdr;
		logic              tail;
	} item_t;

	// crc-16/ccitt-false update by one byte, msb first
	function automatic logic [CRC_W-1:0] crc_add(input logic [CRC_W-1:0] crc,
			input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < BYTE_W; k++) begin
			if (c[CRC_W-1])
				c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
			else
				c = {c[CRC_W-2:0], 1'b0};
		end
		return c;
	endfunction

endpackage

// ----- src/sfr_if.sv -----
// sfr interfaces: payload byte channel, framed byte channel, config write channel
// depends on sfr_pkg
interface sfr_in_if;
	import sfr_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] payload_byte;
	modport source(output valid, output payload_byte, input ready);
	modport sink(input valid, input payload_byte, output ready);
endinterface

interface sfr_out_if;
	import sfr_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              last_in_run;
	logic              end_of_frame;
	modport source(output valid, output out_byte, output last_in_run, output end_of_frame,
		input ready);
	modport sink(input valid, input out_byte, input last_in_run, input end_of_frame,
		output ready);
endinterface

interface sfr_cfg_if;
	import sfr_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] reg_index;
	logic [BYTE_W-1:0]    wr_data;
	modport source(output valid, output reg_index, output wr_data, input ready);
	modport sink(input valid, input reg_index, input wr_data, output ready);
endinterface

// ----- src/sfr_emit.sv -----
// sfr_emit: holds one prepared run and sends its bytes one per cycle while framed.ready is high
// depends on sfr_pkg and sfr_out_if
module sfr_emit (
	input  logic           clk,
	input  logic           arst_n,
	input  sfr_pkg::item_t item,
	input  logic           item_valid,
	output logic           item_ready,
	sfr_out_if.source      framed
);
	import sfr_pkg::*;

	item_t item_s2;
	logic  valid_s2;
	slot_t slot_q;
	slot_t last_slot;
	logic  out_fire;
	logic  run_done;

	assign last_slot  = item_s2.tail ? SLOT_CRC_LO : SLOT_DATA;
	assign out_fire   = framed.valid && framed.ready;
	assign run_done   = out_fire && (slot_q == last_slot);
	assign item_ready = !valid_s2 || run_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			slot_q   <= SLOT_SYNC_A;
		end else if (item_valid && item_ready) begin
			valid_s2 <= 1'b1;
			slot_q   <= item.hdr ? SLOT_SYNC_A : SLOT_DATA;
		end else if (run_done) begin
			valid_s2 <= 1'b0;
		end else if (out_fire) begin
			slot_q <= slot_t'(slot_q + 3'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready)
			item_s2 <= item;
	end

	always_comb begin
		framed.valid        = valid_s2;
		framed.last_in_run  = (slot_q == last_slot);
		framed.end_of_frame = (slot_q == SLOT_CRC_LO);
		unique case (slot_q)
			SLOT_SYNC_A: framed.out_byte = item_s2.sync_a;
			SLOT_SYNC_B: framed.out_byte = item_s2.sync_b;
			SLOT_LENGTH: framed.out_byte = item_s2.length;
			SLOT_DATA:   framed.out_byte = item_s2.data;
			SLOT_CRC_HI: framed.out_byte = item_s2.crc[CRC_W-1:BYTE_W];
			SLOT_CRC_LO: framed.out_byte = item_s2.crc[BYTE_W-1:0];
			default:     framed.out_byte = item_s2.data;
		endcase
	end

	a_eof_closes_run: assert property (@(posedge clk) disable iff (!arst_n)
		framed.valid && framed.end_of_frame |-> framed.last_in_run)
		else $error("end_of_frame without last_in_run");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && !framed.last_in_run |=> framed.valid)
		else $error("run stopped before its last byte");

	a_header_only_at_start: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (slot_q == SLOT_SYNC_A) |-> item_s2.hdr)
		else $error("sync byte emitted mid frame");

endmodule

// ----- src/sync_length_crc16_framer.sv -----
// sync_length_crc16_framer: top level of the packet framer
// depends on sfr_pkg, sfr_if and sfr_emit
//
// usage
//  - payload: one payload byte per request (valid/ready)
//  - framed: the framed byte stream, one byte per request; last_in_run marks the
//    final byte caused by a payload byte, end_of_frame marks the low crc byte
//  - cfg: register writes (0 payload_length, 1 sync_first, 2 sync_second);
//    always ready, other indexes ignored; write only while the block is idle
//  - frame: sync_first, sync_second, length, payload bytes, crc hi, crc lo
//    crc-16/ccitt-false over the length byte and the payload
//  - path: a payload byte taken is registered in the prepare register, then in
//    the emit register, before its first output byte appears
//  - throughput: one payload byte per cycle mid frame while framed.ready is high;
//    the run of the first byte of a frame holds 4 output bytes, that of the last 3
//    (6 when the length is 1), all sent over the single output byte lane
//  - stall: the prepare register holds one more run while the emit register
//    waits, then payload ready drops until the output drains
//  - reset: registers to 64/0xAA/0x55, position to frame start, crc to 0xFFFF,
//    both pipeline registers empty
module sync_length_crc16_framer (
	input  logic      clk,
	input  logic      arst_n,
	sfr_in_if.sink    payload,
	sfr_out_if.source framed,
	sfr_cfg_if.sink   cfg
);
	import sfr_pkg::*;

	// configuration registers
	logic [BYTE_W-1:0] payload_length_q;
	logic [BYTE_W-1:0] sync_first_q;
	logic [BYTE_W-1:0] sync_second_q;

	// frame state
	logic [BYTE_W-1:0] pos_q;
	logic [CRC_W-1:0]  crc_q;

	// prepare stage
	item_t item_s1;
	logic  valid_s1;
	logic  emit_ready;

	logic              accept;
	logic              hdr;
	logic              tail;
	logic [BYTE_W-1:0] limit;
	logic [BYTE_W:0]   taken;
	logic [CRC_W-1:0]  crc_base;
	logic [CRC_W-1:0]  crc_new;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			payload_length_q <= RST_PAYLOAD_LENGTH;
			sync_first_q     <= RST_SYNC_FIRST;
			sync_second_q    <= RST_SYNC_SECOND;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.reg_index)
				REG_PAYLOAD_LENGTH: payload_length_q <= cfg.wr_data;
				REG_SYNC_FIRST:     sync_first_q     <= cfg.wr_data;
				REG_SYNC_SECOND:    sync_second_q    <= cfg.wr_data;
				default: ;
			endcase
		end
	end

	// take a byte when the prepare register is free or moves on this cycle
	assign payload.ready = !valid_s1 || emit_ready;
	assign accept        = payload.valid && payload.ready;

	// frame start restarts the crc with the length byte folded in
	assign hdr      = (pos_q == '0);
	assign crc_base = hdr ? crc_add(CRC_INIT, payload_length_q) : crc_q;
	assign crc_new  = crc_add(crc_base, payload.payload_byte);

	// zero length still closes after one byte; a shortened length closes at once
	assign limit = (payload_length_q == '0) ? BYTE_W'(1) : payload_length_q;
	assign taken = {1'b0, pos_q} + (BYTE_W+1)'(1);
	assign tail  = (taken >= {1'b0, limit});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			crc_q    <= CRC_INIT;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				pos_q <= tail ? '0 : taken[BYTE_W-1:0];
				crc_q <= tail ? CRC_INIT : crc_new;
			end
			valid_s1 <= accept || (valid_s1 && !emit_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.sync_a <= sync_first_q;
			item_s1.sync_b <= sync_second_q;
			item_s1.length <= payload_length_q;
			item_s1.data   <= payload.payload_byte;
			item_s1.crc    <= crc_new;
			item_s1.hdr    <= hdr;
			item_s1.tail   <= tail;
		end
	end

	sfr_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item_s1),
		.item_valid (valid_s1),
		.item_ready (emit_ready),
		.framed     (framed)
	);

	// the crc is back at its seed whenever a frame has not started
	a_crc_seed_at_start: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q == '0 |-> crc_q == CRC_INIT)
		else $error("crc not reseeded at frame start");

	a_tail_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && tail |=> pos_q == '0)
		else $error("frame position not cleared after last byte");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !emit_ready |=> valid_s1 && $stable(item_s1))
		else $error("prepared run lost while emitter busy");

endmodule
